>>> hw/rtl/obm_pkg.sv
// obm_pkg: shared types and constants of the 1-Wire bus master
// used by the channel interfaces, the register block, the engine and the top level
`default_nettype none

package obm_pkg;

   localparam int unsigned TICK_W    = 10;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned BIT_IDX_W = 3;
   localparam int unsigned CFG_IDX_W = 3;

   localparam logic [TICK_W-1:0] RESET_LOW_DEFAULT      = 10'd480;
   localparam logic [TICK_W-1:0] PRESENCE_SAMPLE_DEFAULT = 10'd60;
   localparam logic [TICK_W-1:0] RESET_RECOVERY_DEFAULT = 10'd420;
   localparam logic [TICK_W-1:0] WRITE_SLOT_DEFAULT     = 10'd60;
   localparam logic [TICK_W-1:0] READ_SAMPLE_DEFAULT    = 10'd14;
   localparam logic [TICK_W-1:0] READ_RECOVERY_DEFAULT  = 10'd420;

   localparam logic [BIT_IDX_W-1:0] LAST_BIT = 3'd7;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_RESET = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [CFG_IDX_W-1:0] {
      CFG_RESET_LOW       = 3'd0,
      CFG_PRESENCE_SAMPLE = 3'd1,
      CFG_RESET_RECOVERY  = 3'd2,
      CFG_WRITE_SLOT      = 3'd3,
      CFG_READ_SAMPLE     = 3'd4,
      CFG_READ_RECOVERY   = 3'd5
   } cfg_index_type;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'b0001,
      PH_PULSE   = 4'b0010,
      PH_WAIT    = 4'b0100,
      PH_RECOVER = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [TICK_W-1:0] reset_low_ticks;
      logic [TICK_W-1:0] presence_sample_ticks;
      logic [TICK_W-1:0] reset_recovery_ticks;
      logic [TICK_W-1:0] write_slot_ticks;
      logic [TICK_W-1:0] read_sample_ticks;
      logic [TICK_W-1:0] read_recovery_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [BYTE_W-1:0] data_byte;
      logic              line_level;
   } item_type;

   typedef struct packed {
      logic              drive_low;
      logic              busy_res;
      logic              done_res;
      logic              presence;
      logic [BYTE_W-1:0] read_byte;
   } result_type;

endpackage

`default_nettype wire

>>> hw/rtl/obm_if.sv
// obm_req_if and obm_rsp_if: valid/ready channels of the 1-Wire bus master
// depends on obm_pkg for field widths
`default_nettype none

interface obm_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  command;
   logic [obm_pkg::BYTE_W-1:0]  data_byte;
   logic                        line_level;

   modport source (output valid, output command, output data_byte, output line_level,
                   input ready);
   modport sink   (input valid, input command, input data_byte, input line_level,
                   output ready);
endinterface

interface obm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        drive_low;
   logic                        busy_res;
   logic                        done_res;
   logic                        presence;
   logic [obm_pkg::BYTE_W-1:0]  read_byte;

   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output presence, output read_byte, input ready);
   modport sink   (input valid, input drive_low, input busy_res, input done_res,
                   input presence, input read_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/obm_csr.sv
// obm_csr: timing registers of the 1-Wire bus master, written through a plain write port
// depends on obm_pkg
`default_nettype none

module obm_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_en,
   input  wire logic [obm_pkg::CFG_IDX_W-1:0]   csr_index,
   input  wire logic [obm_pkg::TICK_W-1:0]      csr_write_data,
   output obm_pkg::cfg_type                     cfg
);

   obm_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            obm_pkg::CFG_RESET_LOW:       cfg_in.reset_low_ticks       = csr_write_data;
            obm_pkg::CFG_PRESENCE_SAMPLE: cfg_in.presence_sample_ticks = csr_write_data;
            obm_pkg::CFG_RESET_RECOVERY:  cfg_in.reset_recovery_ticks  = csr_write_data;
            obm_pkg::CFG_WRITE_SLOT:      cfg_in.write_slot_ticks      = csr_write_data;
            obm_pkg::CFG_READ_SAMPLE:     cfg_in.read_sample_ticks     = csr_write_data;
            obm_pkg::CFG_READ_RECOVERY:   cfg_in.read_recovery_ticks   = csr_write_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks       <= obm_pkg::RESET_LOW_DEFAULT;
         cfg_ff.presence_sample_ticks <= obm_pkg::PRESENCE_SAMPLE_DEFAULT;
         cfg_ff.reset_recovery_ticks  <= obm_pkg::RESET_RECOVERY_DEFAULT;
         cfg_ff.write_slot_ticks      <= obm_pkg::WRITE_SLOT_DEFAULT;
         cfg_ff.read_sample_ticks     <= obm_pkg::READ_SAMPLE_DEFAULT;
         cfg_ff.read_recovery_ticks   <= obm_pkg::READ_RECOVERY_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> hw/rtl/obm_engine.sv
// obm_engine: bus timing state and the per-tick step of the 1-Wire bus master
// depends on obm_pkg; advances once per tick beat taken from the input register
`default_nettype none

module obm_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_en,
   input  obm_pkg::item_type         item,
   input  obm_pkg::cfg_type          cfg,
   output obm_pkg::result_type       result
);

   obm_pkg::phase_type                 phase_ff, phase_in, eff_phase;
   obm_pkg::cmd_type                   op_ff, op_in, eff_op;
   logic [obm_pkg::TICK_W-1:0]         count_ff, count_in, eff_count, count_inc, limit;
   logic [obm_pkg::BIT_IDX_W-1:0]      bit_ff, bit_in, eff_bit;
   logic [obm_pkg::BYTE_W-1:0]         shift_ff, shift_in, eff_shift;
   logic [obm_pkg::BYTE_W-1:0]         last_ff, last_in;
   logic                               pres_ff, pres_in;
   logic                               start, reached, drive, done;

   // a command taken in idle acts on the same tick
   always_comb begin
      start     = (phase_ff == obm_pkg::PH_IDLE) &&
                  (obm_pkg::cmd_type'(item.command) != obm_pkg::CMD_NONE);
      eff_phase = start ? obm_pkg::PH_PULSE : phase_ff;
      eff_op    = start ? obm_pkg::cmd_type'(item.command) : op_ff;
      eff_count = start ? '0 : count_ff;
      eff_bit   = start ? '0 : bit_ff;
      eff_shift = shift_ff;
      if (start) begin
         eff_shift = (obm_pkg::cmd_type'(item.command) == obm_pkg::CMD_WRITE) ?
                     item.data_byte : '0;
      end
   end

   always_comb begin
      limit = cfg.read_recovery_ticks;
      if (eff_op == obm_pkg::CMD_RESET) begin
         priority case (1'b1)
            eff_phase == obm_pkg::PH_PULSE: limit = cfg.reset_low_ticks;
            eff_phase == obm_pkg::PH_WAIT:  limit = cfg.presence_sample_ticks;
            default:                        limit = cfg.reset_recovery_ticks;
         endcase
      end else if (eff_op == obm_pkg::CMD_WRITE) begin
         limit = cfg.write_slot_ticks;
      end else if (eff_phase == obm_pkg::PH_WAIT) begin
         limit = cfg.read_sample_ticks;
      end
      count_inc = eff_count + 1'b1;
      // a zero limit behaves like a limit of one
      reached   = (count_inc >= limit);
   end

   always_comb begin
      phase_in = eff_phase;
      op_in    = eff_op;
      count_in = eff_count;
      bit_in   = eff_bit;
      shift_in = eff_shift;
      pres_in  = pres_ff;
      last_in  = last_ff;
      drive    = 1'b0;
      done     = 1'b0;
      unique case (eff_phase)
         obm_pkg::PH_IDLE: begin
            phase_in = obm_pkg::PH_IDLE;
         end
         obm_pkg::PH_PULSE: begin
            drive = 1'b1;
            if (eff_op == obm_pkg::CMD_RESET) begin
               count_in = count_inc;
               if (reached) begin
                  phase_in = obm_pkg::PH_WAIT;
                  count_in = '0;
               end
            end else begin
               phase_in = obm_pkg::PH_WAIT;
               count_in = '0;
            end
         end
         obm_pkg::PH_WAIT: begin
            count_in = count_inc;
            if (eff_op == obm_pkg::CMD_RESET) begin
               if (reached) begin
                  pres_in  = ~item.line_level;
                  phase_in = obm_pkg::PH_RECOVER;
                  count_in = '0;
               end
            end else if (eff_op == obm_pkg::CMD_WRITE) begin
               drive = ~eff_shift[0];
               if (reached) begin
                  shift_in = {1'b0, eff_shift[obm_pkg::BYTE_W-1:1]};
                  count_in = '0;
                  if (eff_bit == obm_pkg::LAST_BIT) begin
                     bit_in   = '0;
                     phase_in = obm_pkg::PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     bit_in   = eff_bit + 1'b1;
                     phase_in = obm_pkg::PH_PULSE;
                  end
               end
            end else begin
               if (reached) begin
                  shift_in = {item.line_level, eff_shift[obm_pkg::BYTE_W-1:1]};
                  phase_in = obm_pkg::PH_RECOVER;
                  count_in = '0;
               end
            end
         end
         obm_pkg::PH_RECOVER: begin
            count_in = count_inc;
            if (reached) begin
               count_in = '0;
               if (eff_op == obm_pkg::CMD_RESET) begin
                  phase_in = obm_pkg::PH_IDLE;
                  done     = 1'b1;
               end else if (eff_bit == obm_pkg::LAST_BIT) begin
                  bit_in   = '0;
                  phase_in = obm_pkg::PH_IDLE;
                  last_in  = eff_shift;
                  done     = 1'b1;
               end else begin
                  bit_in   = eff_bit + 1'b1;
                  phase_in = obm_pkg::PH_PULSE;
               end
            end
         end
         default: begin
            phase_in = obm_pkg::PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= obm_pkg::PH_IDLE;
         op_ff    <= obm_pkg::CMD_NONE;
         count_ff <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         pres_ff  <= 1'b0;
         last_ff  <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         count_ff <= count_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         pres_ff  <= pres_in;
         last_ff  <= last_in;
      end
   end

   always_comb begin
      result.drive_low = drive;
      result.busy_res  = (eff_phase != obm_pkg::PH_IDLE);
      result.done_res  = done;
      result.presence  = pres_in;
      result.read_byte = last_in;
   end

endmodule

`default_nettype wire

>>> hw/rtl/onewire_bus_master.sv
// onewire_bus_master: top level, input register, engine and result register
// depends on obm_pkg, obm_req_if, obm_rsp_if, obm_csr and obm_engine
//
//   channel  | dir | handshake              | payload
//   req_if   | in  | valid/ready            | command, data_byte, line_level
//   rsp_if   | out | valid/ready            | drive_low, busy_res, done_res, presence, read_byte
//   csr_*    | in  | write enable, no ready | csr_index, csr_write_data
//
// one tick beat per cycle sustained while rsp_if.ready holds; a result passes the input and result registers
// the engine steps once per cycle, unless stalled, from the input register into the result register
// reset clears all timing state and loads the default register values
// a stall on rsp_if holds the result register, then the input register, then req_if.ready
`default_nettype none

module onewire_bus_master (
   input  wire logic                            clock,
   input  wire logic                            reset,
   obm_req_if.sink                              req_if,
   obm_rsp_if.source                            rsp_if,
   input  wire logic                            csr_write_en,
   input  wire logic [obm_pkg::CFG_IDX_W-1:0]   csr_index,
   input  wire logic [obm_pkg::TICK_W-1:0]      csr_write_data
);

   obm_pkg::cfg_type    cfg;
   obm_pkg::item_type   item_ff;
   obm_pkg::result_type step_result, rsp_data_ff;
   logic                item_vld_ff, item_vld_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic                advance, req_fire;

   obm_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   obm_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // the held tick moves on once the result register is free or being emptied
   assign advance      = item_vld_ff && (!rsp_vld_ff || rsp_if.ready);
   assign req_if.ready = !item_vld_ff || advance;
   assign req_fire     = req_if.valid && req_if.ready;

   always_comb begin
      item_vld_in = item_vld_ff;
      if (req_fire) begin
         item_vld_in = 1'b1;
      end else if (advance) begin
         item_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         item_vld_ff <= item_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.command    <= req_if.command;
         item_ff.data_byte  <= req_if.data_byte;
         item_ff.line_level <= req_if.line_level;
      end
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_if.valid     = rsp_vld_ff;
   assign rsp_if.drive_low = rsp_data_ff.drive_low;
   assign rsp_if.busy_res  = rsp_data_ff.busy_res;
   assign rsp_if.done_res  = rsp_data_ff.done_res;
   assign rsp_if.presence  = rsp_data_ff.presence;
   assign rsp_if.read_byte = rsp_data_ff.read_byte;

endmodule

`default_nettype wire

>>> hw/rtl/obm_checker.sv
// obm_checker: port-level checks on the 1-Wire bus master, bound to the top level
// depends on obm_pkg for widths
`default_nettype none

module obm_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic                           rsp_busy,
   input wire logic                           rsp_done,
   input wire logic                           rsp_presence,
   input wire logic [obm_pkg::BYTE_W-1:0]     rsp_read_byte
);

   logic [1:0]                  pending_ff, pending_in;
   logic                        prev_busy_ff, prev_done_ff, prev_pres_ff;
   logic [obm_pkg::BYTE_W-1:0]  prev_byte_ff;
   logic                        req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         prev_busy_ff <= 1'b0;
         prev_done_ff <= 1'b0;
         prev_pres_ff <= 1'b0;
         prev_byte_ff <= '0;
      end else begin
         pending_ff <= pending_in;
         if (rsp_fire) begin
            prev_busy_ff <= rsp_busy;
            prev_done_ff <= rsp_done;
            prev_pres_ff <= rsp_presence;
            prev_byte_ff <= rsp_read_byte;
         end
      end
   end

   // every result beat belongs to a tick taken earlier
   a_no_orphan_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> pending_ff != 2'd0)
      else $error("result beat without an outstanding tick");

   // an operation runs on until its done beat
   a_busy_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && prev_busy_ff && !prev_done_ff |-> rsp_busy)
      else $error("operation ended without a done beat");

   // the read byte only changes on a done beat
   a_read_byte_held: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_done |-> rsp_read_byte == prev_byte_ff)
      else $error("read byte changed outside a done beat");

   // presence only changes while a bus reset runs
   a_presence_held: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && (rsp_presence != prev_pres_ff) |-> rsp_busy)
      else $error("presence changed while idle");

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat withdrawn while stalled");

endmodule

bind onewire_bus_master obm_checker u_obm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_busy      (rsp_if.busy_res),
   .rsp_done      (rsp_if.done_res),
   .rsp_presence  (rsp_if.presence),
   .rsp_read_byte (rsp_if.read_byte)
);

`default_nettype wire
